// ----- sv/vrmir_pkg.sv -----
`default_nettype none

package vrmir_pkg;

    // Memory sizes and the address widths that follow from them.
    localparam int VRAM_BYTES   = 16384;
    localparam int SPRITE_BYTES = 256;
    localparam int VRAM_AW      = $clog2(VRAM_BYTES);
    localparam int OAM_AW       = $clog2(SPRITE_BYTES);

    // Field widths of the channels.
    localparam int MODE_W    = 3;
    localparam int REG_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int SCROLL_W  = 15;
    localparam int FINE_W    = 3;
    localparam int PTR_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [VRAM_AW-1:0] vaddr_t;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_VBLANK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PRERENDER = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SPR0_HIT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OVERFLOW  = 3'd5;

    // Bus register numbers.
    localparam logic [REG_W-1:0] REG_CTRL     = 3'd0;
    localparam logic [REG_W-1:0] REG_MASK     = 3'd1;
    localparam logic [REG_W-1:0] REG_STATUS   = 3'd2;
    localparam logic [REG_W-1:0] REG_OAM_ADDR = 3'd3;
    localparam logic [REG_W-1:0] REG_OAM_DATA = 3'd4;
    localparam logic [REG_W-1:0] REG_SCROLL   = 3'd5;
    localparam logic [REG_W-1:0] REG_ADDR     = 3'd6;
    localparam logic [REG_W-1:0] REG_DATA     = 3'd7;

    // Configuration register numbers.
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_BOARD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_UPPER  = 2'd3;

    typedef struct packed {
        logic four_screen;
        logic vertical;
        logic single_board;
        logic single_upper;
    } cfg_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_WAIT1 = 5'b00100,
        S_WAIT2 = 5'b01000,
        S_PUSH  = 5'b10000
    } state_t;

    // Maps a data-port address onto video memory: nametable mirroring
    // below the palette and palette mirroring above it.
    function automatic vaddr_t map_address(logic [PTR_W-1:0] a, cfg_t cfg);
        vaddr_t     a14;
        logic [9:0] low;
        logic [1:0] nt;
        vaddr_t     p;
        vaddr_t     m;
        a14 = a[VRAM_AW-1:0];
        low = a[9:0];
        nt  = a[11:10];
        p   = a14 & 14'h3F1F;
        if (a14 < 14'h2000) begin
            m = a14;
        end
        else if (a14 < 14'h3F00) begin
            if (cfg.single_board) begin
                m = {3'b100, cfg.single_upper, low};
            end
            else if (cfg.four_screen) begin
                m = {2'b10, a14[11:0]};
            end
            else if (nt == 2'd0 || cfg.single_upper) begin
                m = {4'b1000, low};
            end
            else if (nt == 2'd1) begin
                m = {3'b100, cfg.vertical, low};
            end
            else if (nt == 2'd2) begin
                m = {3'b100, !cfg.vertical, low};
            end
            else begin
                m = {4'b1001, low};
            end
        end
        else begin
            // Sprite backdrop entries alias the background ones.
            if (p[4] && p[1:0] == 2'b00) begin
                p[4] = 1'b0;
            end
            m = p;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- sv/vrmir_item_if.sv -----
`default_nettype none

interface vrmir_item_if import vrmir_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [REG_W-1:0]  reg_index;
    logic [BYTE_W-1:0] write_data;

    modport source (output valid, mode, reg_index, write_data, input ready);
    modport sink   (input valid, mode, reg_index, write_data, output ready);
endinterface

`default_nettype wire

// ----- sv/vrmir_result_if.sv -----
`default_nettype none

interface vrmir_result_if import vrmir_pkg::*;;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   read_data;
    logic                nmi_pulse;
    logic [SCROLL_W-1:0] scroll_current;
    logic [FINE_W-1:0]   scroll_fine_x;

    modport source (output valid, read_data, nmi_pulse, scroll_current, scroll_fine_x,
                    input ready);
    modport sink   (input valid, read_data, nmi_pulse, scroll_current, scroll_fine_x,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/vrmir_cfg_if.sv -----
`default_nettype none

interface vrmir_cfg_if import vrmir_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic                 data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/vrmir_ram.sv -----
`default_nettype none

module vrmir_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/vrmir_core.sv -----
`default_nettype none

module vrmir_core import vrmir_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    vrmir_item_if.sink         item,
    vrmir_result_if.source     result,
    vrmir_cfg_if.sink          cfg,
    // Video memory port
    output logic               vram_we,
    output vaddr_t             vram_waddr,
    output logic [BYTE_W-1:0]  vram_wdata,
    output logic               vram_re,
    output vaddr_t             vram_raddr,
    input  wire logic [BYTE_W-1:0] vram_rdata,
    // Sprite memory port
    output logic               oam_we,
    output logic [OAM_AW-1:0]  oam_waddr,
    output logic [BYTE_W-1:0]  oam_wdata,
    output logic               oam_re,
    output logic [OAM_AW-1:0]  oam_raddr,
    input  wire logic [BYTE_W-1:0] oam_rdata
);

    state_t              state_reg, state_next;
    cfg_t                cfg_reg;
    logic [VRAM_AW:0]    clear_cnt_reg;
    logic                clearing;

    logic [MODE_W-1:0]   mode_reg;
    logic [REG_W-1:0]    idx_reg;
    logic [BYTE_W-1:0]   wdata_reg;

    logic                ctrl_nmi_reg, ctrl_nmi_next;
    logic                ctrl_inc_reg, ctrl_inc_next;
    logic [1:0]          mask_reg, mask_next;
    logic [2:0]          status_reg, status_next;
    logic [OAM_AW-1:0]   spr_ptr_reg, spr_ptr_next;
    logic [PTR_W-1:0]    data_ptr_reg, data_ptr_next;
    logic [BYTE_W-1:0]   rd_buf_reg, rd_buf_next;
    logic [4:0]          last_wr_reg, last_wr_next;
    logic [SCROLL_W-1:0] temp_reg, temp_next;
    logic [SCROLL_W-1:0] now_reg, now_next;
    logic [FINE_W-1:0]   fine_x_reg, fine_x_next;
    logic                toggle_reg, toggle_next;
    logic                vblank_reg, vblank_next;

    logic [BYTE_W-1:0]   res_data_reg, res_data_next;
    logic                res_nmi_reg, res_nmi_next;

    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_data_reg;
    logic                out_nmi_reg;
    logic [SCROLL_W-1:0] out_scroll_reg;
    logic [FINE_W-1:0]   out_fine_reg;
    logic                push;

    vaddr_t              map_ptr;
    vaddr_t              map_mirror;
    logic [PTR_W-1:0]    ptr_step;
    logic [BYTE_W-1:0]   open_bus;
    logic                item_vram_re;
    vaddr_t              item_vram_raddr;
    logic                item_vram_we;
    logic                item_oam_we;

    assign clearing  = !clear_cnt_reg[VRAM_AW];
    assign map_ptr    = map_address(data_ptr_reg, cfg_reg);
    assign map_mirror = map_address(data_ptr_reg & 16'h2FFF, cfg_reg);
    assign ptr_step   = data_ptr_reg + (ctrl_inc_reg ? PTR_W'(32) : PTR_W'(1));
    assign open_bus   = {status_reg, last_wr_reg};

    assign item.ready = (state_reg == S_IDLE) && !clearing;
    assign cfg.ready  = 1'b1;

    assign push = (state_reg == S_PUSH) && (!out_valid_reg || result.ready);

    // Clearing sweep after reset, then the one item in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FOUR_SCREEN:  cfg_reg.four_screen  <= cfg.data;
                CFG_VERTICAL:     cfg_reg.vertical     <= cfg.data;
                CFG_SINGLE_BOARD: cfg_reg.single_board <= cfg.data;
                CFG_SINGLE_UPPER: cfg_reg.single_upper <= cfg.data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            mode_reg  <= item.mode;
            idx_reg   <= item.reg_index;
            wdata_reg <= item.write_data;
        end
    end

    // Memory ports: the clearing sweep owns the write ports until it ends.
    always_comb
    begin
        vram_we    = clearing || item_vram_we;
        vram_waddr = clearing ? clear_cnt_reg[VRAM_AW-1:0] : map_ptr;
        vram_wdata = clearing ? '0 : wdata_reg;
        vram_re    = item_vram_re;
        vram_raddr = item_vram_raddr;
        oam_we     = (clearing && clear_cnt_reg[VRAM_AW-1:OAM_AW] == '0) || item_oam_we;
        oam_waddr  = clearing ? clear_cnt_reg[OAM_AW-1:0] : spr_ptr_reg;
        oam_wdata  = clearing ? '0 : wdata_reg;
        oam_re     = (state_reg == S_EXEC) && (mode_reg == MODE_READ)
                     && (idx_reg == REG_OAM_DATA);
        oam_raddr  = spr_ptr_reg;
    end

    // Register file update and sequencing.
    always_comb
    begin
        state_next    = state_reg;
        ctrl_nmi_next = ctrl_nmi_reg;
        ctrl_inc_next = ctrl_inc_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        spr_ptr_next  = spr_ptr_reg;
        data_ptr_next = data_ptr_reg;
        rd_buf_next   = rd_buf_reg;
        last_wr_next  = last_wr_reg;
        temp_next     = temp_reg;
        now_next      = now_reg;
        fine_x_next   = fine_x_reg;
        toggle_next   = toggle_reg;
        vblank_next   = vblank_reg;
        res_data_next = res_data_reg;
        res_nmi_next  = res_nmi_reg;
        item_vram_re    = 1'b0;
        item_vram_raddr = map_ptr;
        item_vram_we    = 1'b0;
        item_oam_we     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid && item.ready)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_data_next = '0;
                res_nmi_next  = 1'b0;
                state_next    = S_PUSH;
                case (mode_reg)
                    MODE_READ:
                    begin
                        case (idx_reg)
                            REG_STATUS:
                            begin
                                res_data_next  = open_bus;
                                status_next[2] = 1'b0;
                                toggle_next    = 1'b1;
                            end
                            REG_OAM_DATA:
                            begin
                                state_next = S_WAIT1;
                            end
                            REG_DATA:
                            begin
                                item_vram_re = 1'b1;
                                state_next   = S_WAIT1;
                            end
                            default:
                            begin
                                res_data_next = open_bus;
                            end
                        endcase
                    end

                    MODE_WRITE:
                    begin
                        last_wr_next = wdata_reg[4:0];
                        case (idx_reg)
                            REG_CTRL:
                            begin
                                res_nmi_next    = status_reg[2] && wdata_reg[7] && !ctrl_nmi_reg;
                                ctrl_nmi_next   = wdata_reg[7];
                                ctrl_inc_next   = wdata_reg[2];
                                temp_next[11:10] = wdata_reg[1:0];
                            end
                            REG_MASK:
                            begin
                                mask_next = wdata_reg[4:3];
                            end
                            REG_OAM_ADDR:
                            begin
                                spr_ptr_next = wdata_reg;
                            end
                            REG_OAM_DATA:
                            begin
                                item_oam_we  = 1'b1;
                                spr_ptr_next = spr_ptr_reg + 1'b1;
                            end
                            REG_SCROLL:
                            begin
                                if (toggle_reg)
                                begin
                                    temp_next[4:0] = wdata_reg[7:3];
                                    fine_x_next    = wdata_reg[2:0];
                                end
                                else
                                begin
                                    temp_next[14:12] = wdata_reg[2:0];
                                    temp_next[9:5]   = wdata_reg[7:3];
                                end
                                toggle_next = !toggle_reg;
                            end
                            REG_ADDR:
                            begin
                                data_ptr_next = {data_ptr_reg[7:0], wdata_reg};
                                if (toggle_reg)
                                begin
                                    temp_next = {1'b0, wdata_reg[5:0], temp_reg[7:0]};
                                end
                                else
                                begin
                                    temp_next = {temp_reg[14:8], wdata_reg};
                                    now_next  = {temp_reg[14:8], wdata_reg};
                                end
                                toggle_next = !toggle_reg;
                            end
                            REG_DATA:
                            begin
                                item_vram_we  = 1'b1;
                                data_ptr_next = ptr_step;
                            end
                            default:
                            begin
                                last_wr_next = wdata_reg[4:0];
                            end
                        endcase
                    end

                    MODE_VBLANK:
                    begin
                        status_next[2] = 1'b1;
                        vblank_next    = 1'b1;
                        res_nmi_next   = ctrl_nmi_reg;
                    end

                    MODE_PRERENDER:
                    begin
                        status_next = '0;
                        vblank_next = 1'b0;
                    end

                    MODE_SPR0_HIT:
                    begin
                        status_next[1] = 1'b1;
                    end

                    MODE_OVERFLOW:
                    begin
                        status_next[0] = 1'b1;
                    end

                    default:
                    begin
                        state_next = S_PUSH;
                    end
                endcase
            end

            S_WAIT1:
            begin
                state_next = S_PUSH;
                if (idx_reg == REG_OAM_DATA)
                begin
                    res_data_next = oam_rdata;
                    if (!vblank_reg || mask_reg != 2'b00)
                    begin
                        spr_ptr_next = spr_ptr_reg + 1'b1;
                    end
                end
                else if (map_ptr[VRAM_AW-1:8] == 6'h3F)
                begin
                    // Palette reads return at once; the buffer refills from
                    // the nametable byte underneath.
                    res_data_next   = vram_rdata;
                    item_vram_re    = 1'b1;
                    item_vram_raddr = map_mirror;
                    state_next      = S_WAIT2;
                end
                else
                begin
                    res_data_next = rd_buf_reg;
                    rd_buf_next   = vram_rdata;
                    data_ptr_next = ptr_step;
                end
            end

            S_WAIT2:
            begin
                rd_buf_next   = vram_rdata;
                data_ptr_next = ptr_step;
                state_next    = S_PUSH;
            end

            S_PUSH:
            begin
                if (push)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ctrl_nmi_reg <= 1'b0;
            ctrl_inc_reg <= 1'b0;
            mask_reg     <= '0;
            status_reg   <= 3'b101;
            spr_ptr_reg  <= '0;
            data_ptr_reg <= '0;
            rd_buf_reg   <= '0;
            last_wr_reg  <= '0;
            temp_reg     <= '0;
            now_reg      <= '0;
            fine_x_reg   <= '0;
            toggle_reg   <= 1'b1;
            vblank_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ctrl_nmi_reg <= ctrl_nmi_next;
            ctrl_inc_reg <= ctrl_inc_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            spr_ptr_reg  <= spr_ptr_next;
            data_ptr_reg <= data_ptr_next;
            rd_buf_reg   <= rd_buf_next;
            last_wr_reg  <= last_wr_next;
            temp_reg     <= temp_next;
            now_reg      <= now_next;
            fine_x_reg   <= fine_x_next;
            toggle_reg   <= toggle_next;
            vblank_reg   <= vblank_next;
        end
    end

    // Pending result of the item in flight.
    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
        res_nmi_reg  <= res_nmi_next;
    end

    // Output register: holds a finished result until its transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_data_reg   <= res_data_reg;
            out_nmi_reg    <= res_nmi_reg;
            out_scroll_reg <= now_reg;
            out_fine_reg   <= fine_x_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.read_data      = out_data_reg;
    assign result.nmi_pulse      = out_nmi_reg;
    assign result.scroll_current = out_scroll_reg;
    assign result.scroll_fine_x  = out_fine_reg;

endmodule

`default_nettype wire

// ----- sv/video_register_port_vram_mirroring_top.sv -----
// An accepted item goes to EXEC and then to PUSH, whence its result enters the output register;
// sprite-data and buffered data-port reads pass through WAIT1 on the way, palette reads through
// WAIT1 and WAIT2, as the memories have registered read ports and a palette read also refills
// the buffer through the single video read port. One item is in flight; the output register lets
// the next item in while a result waits. After reset a clearing pass zeroes video and sprite
// memory and holds off items; configuration writes are taken throughout.
`default_nettype none

module video_register_port_vram_mirroring_top import vrmir_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    vrmir_item_if.sink     item,
    vrmir_result_if.source result,
    vrmir_cfg_if.sink      cfg
);

    logic              vram_we;
    vaddr_t            vram_waddr;
    logic [BYTE_W-1:0] vram_wdata;
    logic              vram_re;
    vaddr_t            vram_raddr;
    logic [BYTE_W-1:0] vram_rdata;
    logic              oam_we;
    logic [OAM_AW-1:0] oam_waddr;
    logic [BYTE_W-1:0] oam_wdata;
    logic              oam_re;
    logic [OAM_AW-1:0] oam_raddr;
    logic [BYTE_W-1:0] oam_rdata;

    // Register file and access sequencer.
    vrmir_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg        (cfg),
        .vram_we    (vram_we),
        .vram_waddr (vram_waddr),
        .vram_wdata (vram_wdata),
        .vram_re    (vram_re),
        .vram_raddr (vram_raddr),
        .vram_rdata (vram_rdata),
        .oam_we     (oam_we),
        .oam_waddr  (oam_waddr),
        .oam_wdata  (oam_wdata),
        .oam_re     (oam_re),
        .oam_raddr  (oam_raddr),
        .oam_rdata  (oam_rdata)
    );

    // Video memory.
    vrmir_ram #(.DEPTH(VRAM_BYTES), .WIDTH(BYTE_W)) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .re    (vram_re),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    // Sprite memory.
    vrmir_ram #(.DEPTH(SPRITE_BYTES), .WIDTH(BYTE_W)) u_oam (
        .clk   (clk),
        .we    (oam_we),
        .waddr (oam_waddr),
        .wdata (oam_wdata),
        .re    (oam_re),
        .raddr (oam_raddr),
        .rdata (oam_rdata)
    );

endmodule

`default_nettype wire
